### hw/rtl/anagram_letter_count_difference_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the letter count difference block
// Immediate-cycle and next-cycle checks, compiled out for synthesis.
// ---------------------------------------------------------------------------
`ifndef ANAGRAM_LETTER_COUNT_DIFFERENCE_ASSERT_SVH
`define ANAGRAM_LETTER_COUNT_DIFFERENCE_ASSERT_SVH
`ifndef SYNTHESIS
// check a condition on every clock edge outside reset
`define ALCD_ASSERT(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
// check that a trigger implies a condition in the next cycle
`define ALCD_ASSERT_NEXT(label, clk, rst_n, trig, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) else $error(msg);
`else
`define ALCD_ASSERT(label, clk, rst_n, cond, msg)
`define ALCD_ASSERT_NEXT(label, clk, rst_n, trig, cond, msg)
`endif
`endif

### hw/rtl/alcd_pkg.sv
// ---------------------------------------------------------------------------
// alcd_pkg
// Shared constants and control bundles of the letter count difference block.
// ---------------------------------------------------------------------------
package alcd_pkg;

  localparam int ALCD_ALPHABET_SIZE = 26;
  localparam int ALCD_MAX_LENGTH    = 16384;

  localparam int LETTER_W    = 5;
  localparam int DELETIONS_W = 16;
  // largest value the deletions field can carry
  localparam int DELETIONS_LIMIT = (1 << DELETIONS_W) - 1;

  // control of the shared saturating adder
  typedef struct packed {
    logic neg;       // subtract the b operand
    logic acc_mode;  // clamp to the result range instead of the counter range
  } alu_ctl_t;

  // control of the counter store
  typedef struct packed {
    logic wr_en;     // write one counter
    logic clr_all;   // drop every counter back to zero
  } store_ctl_t;

endpackage

### hw/rtl/anagram_letter_count_difference.sv
// ---------------------------------------------------------------------------
// anagram_letter_count_difference
// Letter histogram L1 distance: deletions needed to make two strings anagrams.
// ---------------------------------------------------------------------------
// Feed the letters of both strings one word at a time, each tagged with the
// string it belongs to; mark the last letter of the pair with final_letter.
// Each letter moves its signed counter by +1 (first string) or -1 (second),
// saturating at +/-MAX_LENGTH; a letter index at or beyond ALPHABET_SIZE
// moves nothing. After the final word the block walks every counter, adds
// up the magnitudes (saturating at 2*MAX_LENGTH, and at 65535), emits the
// sum as one out_deletions word and clears all counters. in_stall holds off
// the next word through the update state and, after a final word, through the
// sum walk, a drain state and a done state that waits while the previous result
// still sits unread in the output register. This comes from the single read port
// of the counter memory and the one saturating adder serving update and sum walk.
// Counters restart at zero after reset with no clearing pass.
// ---------------------------------------------------------------------------
`include "anagram_letter_count_difference_assert.svh"

module anagram_letter_count_difference
  import alcd_pkg::*;
#(
  parameter int ALPHABET_SIZE = ALCD_ALPHABET_SIZE,
  parameter int MAX_LENGTH    = ALCD_MAX_LENGTH
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [LETTER_W-1:0]    in_letter,
  input  logic                   in_second_string,
  input  logic                   in_final_letter,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [DELETIONS_W-1:0] out_deletions
);

  // counter width holds +/-MAX_LENGTH; adder width holds counter or sum plus headroom
  localparam int AW     = $clog2(ALPHABET_SIZE);
  localparam int CNT_W  = $clog2(MAX_LENGTH + 1) + 1;
  localparam int UW     = ((CNT_W > DELETIONS_W + 1) ? CNT_W : DELETIONS_W + 1) + 2;
  localparam int CAP    = (2 * MAX_LENGTH > DELETIONS_LIMIT) ? DELETIONS_LIMIT
                                                             : 2 * MAX_LENGTH;
  localparam logic [AW-1:0] LAST_IDX = AW'(ALPHABET_SIZE - 1);

  // sequencer states
  localparam logic [2:0] ST_IDLE  = 3'd0;  // take a word
  localparam logic [2:0] ST_UPD   = 3'd1;  // read data back, write updated counter
  localparam logic [2:0] ST_SUM   = 3'd2;  // issue one counter read per cycle
  localparam logic [2:0] ST_DRAIN = 3'd3;  // fold in the last read
  localparam logic [2:0] ST_DONE  = 3'd4;  // hand the sum to the output register

  logic [2:0]               st_r, st_nxt;
  logic [AW-1:0]            idx_r, idx_nxt;
  logic [AW-1:0]            wr_addr_r;
  logic                     second_r;
  logic                     final_r;
  logic                     in_range_r;
  logic                     acc_en_r;
  logic signed [UW-1:0]     acc_r;
  logic                     out_valid_r;
  logic [DELETIONS_W-1:0]   out_deletions_r;

  logic                     accept;
  logic                     in_range;
  logic                     load;
  logic [AW-1:0]            raddr;
  logic signed [CNT_W-1:0]  rd_cnt;
  logic signed [UW-1:0]     rd_ext;
  store_ctl_t               store_ctl;
  alu_ctl_t                 alu_ctl;
  logic signed [UW-1:0]     alu_a;
  logic signed [UW-1:0]     alu_b;
  logic signed [UW-1:0]     alu_res;

  assign in_stall = (st_r != ST_IDLE);
  assign accept   = in_valid && !in_stall;
  assign in_range = (int'(in_letter) < ALPHABET_SIZE);

  // result register empties this cycle or already is empty
  assign load = (st_r == ST_DONE) && (!out_valid_r || !out_stall);

  // ---- sequencer ----
  always_comb begin
    st_nxt  = st_r;
    idx_nxt = idx_r;
    unique case (st_r)
      ST_IDLE: begin
        if (accept) begin
          st_nxt = ST_UPD;
        end
      end
      ST_UPD: begin
        idx_nxt = '0;
        st_nxt  = final_r ? ST_SUM : ST_IDLE;
      end
      ST_SUM: begin
        if (idx_r == LAST_IDX) begin
          st_nxt = ST_DRAIN;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      ST_DRAIN: begin
        st_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (load) begin
          st_nxt = ST_IDLE;
        end
      end
      default: begin
        st_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r     <= ST_IDLE;
      idx_r    <= '0;
      acc_en_r <= 1'b0;
    end else begin
      st_r     <= st_nxt;
      idx_r    <= idx_nxt;
      // read issued in the sum walk returns in the next cycle
      acc_en_r <= (st_r == ST_SUM);
    end
  end

  // hold the accepted word for the update cycle
  always_ff @(posedge clk) begin
    if (accept) begin
      wr_addr_r  <= in_range ? AW'(in_letter) : '0;
      second_r   <= in_second_string;
      final_r    <= in_final_letter;
      in_range_r <= in_range;
    end
  end

  // ---- counter store ----
  // keep the read address inside the memory for letters beyond the alphabet
  assign raddr = (st_r == ST_IDLE) ? (in_range ? AW'(in_letter) : '0) : idx_r;

  assign store_ctl.wr_en   = (st_r == ST_UPD) && in_range_r;
  assign store_ctl.clr_all = load;

  alcd_store #(
    .DEPTH  (ALPHABET_SIZE),
    .DATA_W (CNT_W)
  ) u_store (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (store_ctl),
    .waddr (wr_addr_r),
    .wdata (CNT_W'(alu_res)),
    .raddr (raddr),
    .rdata (rd_cnt)
  );

  assign rd_ext = UW'(rd_cnt);

  // ---- shared saturating adder ----
  // update: counter +/- 1 clamped to +/-MAX_LENGTH
  // sum walk: accumulator + |counter| clamped to the result cap
  always_comb begin
    if (acc_en_r) begin
      alu_ctl.acc_mode = 1'b1;
      alu_ctl.neg      = rd_cnt[CNT_W-1];
      alu_a            = acc_r;
      alu_b            = rd_ext;
    end else begin
      alu_ctl.acc_mode = 1'b0;
      alu_ctl.neg      = second_r;
      alu_a            = rd_ext;
      alu_b            = UW'(1);
    end
  end

  alcd_alu #(
    .UW         (UW),
    .MAX_LENGTH (MAX_LENGTH),
    .CAP        (CAP)
  ) u_alu (
    .ctl (alu_ctl),
    .a   (alu_a),
    .b   (alu_b),
    .res (alu_res)
  );

  // start each walk from zero; fold in one counter per cycle
  always_ff @(posedge clk) begin
    if (st_r == ST_UPD) begin
      acc_r <= '0;
    end else if (acc_en_r) begin
      acc_r <= alu_res;
    end
  end

  // ---- output register ----
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_deletions_r <= DELETIONS_W'(acc_r);
    end
  end

  assign out_valid     = out_valid_r;
  assign out_deletions = out_deletions_r;

  // ---- checks ----
  `ALCD_ASSERT(a_alu_no_overlap, clk, rst_n, !((st_r == ST_UPD) && acc_en_r), "adder claimed by update and sum walk together")
  `ALCD_ASSERT(a_sum_capped, clk, rst_n, !load || (acc_r <= UW'(CAP)), "sum beyond cap at result load")
  `ALCD_ASSERT_NEXT(a_walk_step, clk, rst_n, (st_r == ST_SUM) && (idx_r != LAST_IDX), idx_r == AW'($past(idx_r) + 1'b1), "sum walk skipped a counter")
  `ALCD_ASSERT(a_out_from_done, clk, rst_n, !$rose(out_valid_r) || ($past(st_r) == ST_DONE), "result word appeared outside the done state")

endmodule

### hw/rtl/alcd_alu.sv
// ---------------------------------------------------------------------------
// alcd_alu
// Shared saturating add/subtract unit for counter updates and the L1 sum.
// ---------------------------------------------------------------------------
module alcd_alu
  import alcd_pkg::*;
#(
  parameter int UW         = 19,
  parameter int MAX_LENGTH = ALCD_MAX_LENGTH,
  parameter int CAP        = 2 * ALCD_MAX_LENGTH
) (
  input  alu_ctl_t               ctl,
  input  logic signed [UW-1:0]   a,
  input  logic signed [UW-1:0]   b,
  output logic signed [UW-1:0]   res
);

  localparam logic signed [UW-1:0] CNT_HI = UW'(MAX_LENGTH);
  localparam logic signed [UW-1:0] CNT_LO = -CNT_HI;
  localparam logic signed [UW-1:0] SUM_HI = UW'(CAP);
  localparam logic signed [UW-1:0] SUM_LO = '0;

  logic signed [UW-1:0] sum;
  logic signed [UW-1:0] lo;
  logic signed [UW-1:0] hi;

  always_comb begin
    sum = a + (ctl.neg ? -b : b);
    lo  = ctl.acc_mode ? SUM_LO : CNT_LO;
    hi  = ctl.acc_mode ? SUM_HI : CNT_HI;
    if (sum > hi) begin
      res = hi;
    end else if (sum < lo) begin
      res = lo;
    end else begin
      res = sum;
    end
  end

endmodule

### hw/rtl/alcd_store.sv
// ---------------------------------------------------------------------------
// alcd_store
// Counter memory, one write and one registered read port, valid per entry.
// ---------------------------------------------------------------------------
module alcd_store
  import alcd_pkg::*;
#(
  parameter int DEPTH  = ALCD_ALPHABET_SIZE,
  parameter int DATA_W = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  store_ctl_t                  ctl,
  input  logic [$clog2(DEPTH)-1:0]    waddr,
  input  logic signed [DATA_W-1:0]    wdata,
  input  logic [$clog2(DEPTH)-1:0]    raddr,
  output logic signed [DATA_W-1:0]    rdata
);

  logic signed [DATA_W-1:0] mem [DEPTH];
  logic [DEPTH-1:0]         vld_r;
  logic signed [DATA_W-1:0] rd_data_r;
  logic                     rd_vld_r;

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[waddr] <= wdata;
    end
    rd_data_r <= mem[raddr];
  end

  // an entry never written since the last clear reads as zero
  always_ff @(posedge clk) begin
    if (!rst_n || ctl.clr_all) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (ctl.wr_en) begin
        vld_r[waddr] <= 1'b1;
      end
      rd_vld_r <= vld_r[raddr];
    end
  end

  assign rdata = rd_vld_r ? rd_data_r : '0;

endmodule

### test/testbench.sv
// ----------------------------------------------------------------------------
// Letter count difference testbench
// Streams letter words of string pairs into the block, predicts the deletion
// count of every pair and checks each out_deletions word against it.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench
  import alcd_pkg::*;
();

  // clamp of the deletion count: twice the length bound, and the field width
  localparam int DELETION_CAP = (2 * ALCD_MAX_LENGTH > DELETIONS_LIMIT) ?
                                DELETIONS_LIMIT : 2 * ALCD_MAX_LENGTH;
  localparam int LETTER_TOP    = (1 << LETTER_W) - 1;
  // leave room for two final words, each walking every counter
  localparam int SETTLE_CYCLES = 2 * ALCD_ALPHABET_SIZE + 8;
  localparam int HOLD_CYCLES   = 200;

  // idle mix switched in when a word carrying it leaves the pending queue
  typedef enum int {
    IDLE_KEEP,
    IDLE_MOSTLY_RECEIVER,
    IDLE_MOSTLY_SENDER,
    IDLE_NONE
  } idle_mode_t;

  typedef struct {
    logic [LETTER_W-1:0] letter;
    logic                second_string;
    logic                final_letter;
    bit                  drain_first;  // wait for every pending result first
    idle_mode_t          idle_mode;
    bit                  start_hold;   // start a long receiver hold-off
  } letter_word_t;

  logic                   clk;
  logic                   rst_n            = 1'b0;
  logic                   in_valid         = 1'b0;
  logic                   in_stall;
  logic [LETTER_W-1:0]    in_letter        = '0;
  logic                   in_second_string = 1'b0;
  logic                   in_final_letter  = 1'b0;
  logic                   out_valid;
  logic                   out_stall        = 1'b0;
  logic [DELETIONS_W-1:0] out_deletions;

  letter_word_t           pending_words [$];
  logic [DELETIONS_W-1:0] deletions_due [$];
  // signed per-letter balance: first string counts up, second counts down
  logic signed [15:0]     letter_balance [ALCD_ALPHABET_SIZE];

  int words_queued   = 0;
  int words_accepted = 0;
  int mismatch_count = 0;
  int send_idle_pct  = 0;
  int recv_idle_pct  = 0;
  int hold_requests  = 0;
  int holds_served   = 0;
  int hold_left      = 0;
  int quiet_cycles   = 0;

  anagram_letter_count_difference u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_letter        (in_letter),
    .in_second_string (in_second_string),
    .in_final_letter  (in_final_letter),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_deletions    (out_deletions)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic report_mismatch(input string what);
    $display("mismatch at %0t: %s", $realtime, what);
    mismatch_count++;
  endtask

  function automatic void clear_balances();
    foreach (letter_balance[i]) letter_balance[i] = '0;
  endfunction

  // Apply one accepted word to the balances; on a final word, sum the
  // magnitudes, clamp, queue the expected count and drop every balance.
  function automatic void count_letter(input logic [LETTER_W-1:0] letter,
                                       input logic second, input logic last);
    int total;
    int v;
    total = 0;
    if (letter < ALCD_ALPHABET_SIZE) begin
      if (second) begin
        if (letter_balance[letter] > -ALCD_MAX_LENGTH)
          letter_balance[letter] = letter_balance[letter] - 1;
      end else if (letter_balance[letter] < ALCD_MAX_LENGTH) begin
        letter_balance[letter] = letter_balance[letter] + 1;
      end
    end
    if (last) begin
      foreach (letter_balance[i]) begin
        v = letter_balance[i];
        total += (v < 0) ? -v : v;
      end
      if (total > DELETION_CAP) total = DELETION_CAP;
      deletions_due.push_back(total[DELETIONS_W-1:0]);
      clear_balances();
    end
  endfunction

  function automatic void add_word(input int letter, input bit second, input bit last,
                                   input bit drain_first, input idle_mode_t mode,
                                   input bit start_hold);
    letter_word_t w;
    w.letter        = letter[LETTER_W-1:0];
    w.second_string = second;
    w.final_letter  = last;
    w.drain_first   = drain_first;
    w.idle_mode     = mode;
    w.start_hold    = start_hold;
    pending_words.push_back(w);
    words_queued++;
  endfunction

  // Queue one string pair with random content and return its word count.
  // Half the pairs are exact anagrams (second string is the first reversed),
  // the rest carry random tags; a few letters fall outside the alphabet.
  function automatic int add_random_pair(input int longest, input bit drain_first,
                                         input idle_mode_t mode, input bit start_hold);
    int picked [$];
    int count;
    int span;
    int total;
    bit anagram;
    count   = $urandom_range(longest, 1);
    span    = $urandom_range(1) ? 3 : ALCD_ALPHABET_SIZE - 1;
    anagram = $urandom_range(1);
    for (int i = 0; i < count; i++)
      picked.push_back(($urandom_range(19) == 0) ?
                       $urandom_range(LETTER_TOP, ALCD_ALPHABET_SIZE) : $urandom_range(span));
    total = anagram ? 2 * count : count;
    for (int i = 0; i < total; i++) begin
      if (anagram)
        add_word((i < count) ? picked[i] : picked[total - 1 - i], i >= count,
                 i == total - 1, drain_first && i == 0,
                 (i == 0) ? mode : IDLE_KEEP, start_hold && i == 0);
      else
        add_word(picked[i], $urandom_range(1), i == total - 1, drain_first && i == 0,
                 (i == 0) ? mode : IDLE_KEEP, start_hold && i == 0);
    end
    return total;
  endfunction

  // Driver: offer the next pending word whenever the bus is free. Hold the
  // payload while stalled; predict on every accepted word.
  always @(posedge clk) begin
    letter_word_t w;
    logic drive_valid;
    if (!rst_n) begin
      in_valid <= 1'b0;
      clear_balances();
      quiet_cycles = 0;
    end else begin
      drive_valid = in_valid;
      if (in_valid && !in_stall) begin
        count_letter(in_letter, in_second_string, in_final_letter);
        words_accepted++;
        drive_valid = 1'b0;
      end
      // count cycles with nothing in flight, for drain points
      if (deletions_due.size() == 0 && !in_valid) quiet_cycles++;
      else quiet_cycles = 0;
      if (!drive_valid && pending_words.size() != 0 &&
          !(pending_words[0].drain_first && quiet_cycles < SETTLE_CYCLES) &&
          $urandom_range(99) >= send_idle_pct) begin
        w = pending_words.pop_front();
        in_letter        <= w.letter;
        in_second_string <= w.second_string;
        in_final_letter  <= w.final_letter;
        drive_valid = 1'b1;
        if (w.start_hold) hold_requests <= hold_requests + 1;
        case (w.idle_mode)
          IDLE_MOSTLY_RECEIVER: begin
            send_idle_pct <= 23;
            recv_idle_pct <= 59;
          end
          IDLE_MOSTLY_SENDER: begin
            send_idle_pct <= 59;
            recv_idle_pct <= 23;
          end
          IDLE_NONE: begin
            send_idle_pct <= 0;
            recv_idle_pct <= 0;
          end
          default: ;
        endcase
      end
      in_valid <= drive_valid;
    end
  end

  // Monitor: check each accepted deletions word against the oldest
  // expectation, then pick the stall for the next cycle.
  always @(posedge clk) begin
    logic [DELETIONS_W-1:0] want;
    logic stall_next;
    if (!rst_n) begin
      out_stall <= 1'b0;
      hold_left = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (deletions_due.size() == 0) begin
          report_mismatch($sformatf("deletions %0d with no pair pending", out_deletions));
        end else begin
          want = deletions_due.pop_front();
          if (out_deletions !== want)
            report_mismatch($sformatf("deletions %0d, want %0d", out_deletions, want));
        end
      end
      // a fresh hold request stalls the output long enough to back up the input
      if (holds_served != hold_requests) begin
        holds_served = hold_requests;
        hold_left    = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        stall_next = 1'b1;
      end else begin
        stall_next = $urandom_range(99) < recv_idle_pct;
      end
      out_stall <= stall_next;
    end
  end

  // Stimulus, then end of run.
  initial begin
    int placed;

    // directed pairs: single-letter pair at the bottom of the alphabet
    add_word(0, 0, 1, 0, IDLE_MOSTLY_RECEIVER, 0);
    // same top letter in both strings cancels out
    add_word(ALCD_ALPHABET_SIZE - 1, 1, 0, 0, IDLE_KEEP, 0);
    add_word(ALCD_ALPHABET_SIZE - 1, 0, 1, 0, IDLE_KEEP, 0);
    // letters past the alphabet move nothing, yet a final one still ends the pair
    add_word(LETTER_TOP, 0, 0, 0, IDLE_KEEP, 0);
    add_word(ALCD_ALPHABET_SIZE, 1, 1, 0, IDLE_KEEP, 0);
    // mixed balances: a+1, b-1, c+2, d-1
    add_word(0, 0, 0, 0, IDLE_KEEP, 0);
    add_word(1, 1, 0, 0, IDLE_KEEP, 0);
    add_word(2, 0, 0, 0, IDLE_KEEP, 0);
    add_word(2, 0, 0, 0, IDLE_KEEP, 0);
    add_word(3, 1, 1, 0, IDLE_KEEP, 0);
    // empty pair made of one ignored letter
    add_word(LETTER_TOP - 1, 0, 1, 0, IDLE_KEEP, 0);
    // abc against cba
    for (int i = 0; i < 6; i++)
      add_word((i < 3) ? i : 5 - i, i >= 3, i == 5, 0, IDLE_KEEP, 0);

    placed = 0;
    while (placed < 130) placed += add_random_pair(12, 0, IDLE_KEEP, 0);

    // swap the idle mix once the block is quiet
    placed = add_random_pair(12, 1, IDLE_MOSTLY_SENDER, 0);
    while (placed < 130) placed += add_random_pair(12, 0, IDLE_KEEP, 0);

    // back-pressure: short pairs keep finals coming while the output is held
    placed = add_random_pair(3, 1, IDLE_NONE, 1);
    while (placed < 40) placed += add_random_pair(3, 0, IDLE_KEEP, 0);

    // pause until every result is in, then run with no idling
    placed = add_random_pair(12, 1, IDLE_KEEP, 0);
    while (placed < 130) placed += add_random_pair(12, 0, IDLE_KEEP, 0);

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    while (words_accepted != words_queued) @(posedge clk);
    while (deletions_due.size() != 0) @(posedge clk);
    // let any stray result surface before deciding
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Watchdog: a clean run, even with every word final and the longest stalls,
  // ends long before this deadline; a hung run ends as a failure.
  initial begin
    #2_000_000;
    $display("status: fail");
    $finish;
  end

endmodule

### files.f
+incdir+hw/rtl
hw/rtl/alcd_pkg.sv
hw/rtl/alcd_alu.sv
hw/rtl/alcd_store.sv
hw/rtl/anagram_letter_count_difference.sv
test/testbench.sv
